// ----- hdl/ssrs_pkg.sv -----
// Shared field widths, entry type and reset constant for the seek scheduler.
package ssrs_pkg;

  localparam int ID_W  = 8;
  localparam int TRK_W = 16;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] QUEUE_LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TRK_W-1:0] track;
  } entry_t;

endpackage

// ----- hdl/shortest_seek_request_scheduler_core.sv -----
// Shortest-seek-first request scheduler built around one request memory.
//
//  channel | signals                                        | role
//  --------+------------------------------------------------+--------------------------
//  in      | in_valid, in_stall, in_requester_id, in_track  | requests, appended in order
//  out     | out_valid, out_stall, out_served_*             | zero or one served request
//  cfg     | cfg_valid, cfg_ready, cfg_queue_limit          | service trigger level
//
// A serving request scans with one memory read per entry for the nearest track, loads
// the result into the output register once the output is free, then does one read/write
// per entry behind the served one to close the gap. The single read port serialises
// these steps. Reset (rst_n, synchronous) empties the store logically; the memory
// itself is not cleared. A stalled result holds the next service in ST_OUT, and appends
// stay stalled while it waits; appends before that service are not blocked.
module shortest_seek_request_scheduler_core #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ssrs_pkg::ID_W-1:0]  in_requester_id,
  input  logic [ssrs_pkg::TRK_W-1:0] in_track,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ssrs_pkg::ID_W-1:0]  out_served_requester,
  output logic [ssrs_pkg::TRK_W-1:0] out_served_track,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ssrs_pkg::CFG_W-1:0] cfg_queue_limit
);

  localparam int IW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int EW = (CW > ssrs_pkg::CFG_W) ? CW : ssrs_pkg::CFG_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT, ST_COMPACT} state_t;

  state_t                       state_r;
  logic [ssrs_pkg::CFG_W-1:0]   queue_limit_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                iss_r;
  logic                         rd_vld_r;
  logic [IW-1:0]                rd_idx_r;
  logic [ssrs_pkg::TRK_W-1:0]   last_track_r;
  logic                         served_any_r;
  logic [ssrs_pkg::TRK_W-1:0]   best_r;
  logic [IW-1:0]                pick_r;
  ssrs_pkg::entry_t             best_ent_r;
  logic                         out_valid_r;
  ssrs_pkg::entry_t             out_ent_r;

  ssrs_pkg::entry_t             mem [MAX_DEPTH];
  ssrs_pkg::entry_t             rd_data_r;
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  ssrs_pkg::entry_t             wr_data;
  logic [IW-1:0]                rd_addr;

  logic                         in_acc;
  logic [EW-1:0]                cfg_ext;
  logic [EW-1:0]                lim;
  logic [CW-1:0]                cnt_inc;
  logic                         serve_now;
  logic [ssrs_pkg::TRK_W-1:0]   seek_gap;
  logic                         take;
  logic                         rd_last;
  logic [CW-1:0]                pick_next;
  logic                         out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid            = out_valid_r;
  assign out_served_requester = out_ent_r.id;
  assign out_served_track     = out_ent_r.track;

  // A limit of zero acts as one, and a limit above the depth acts as the depth.
  assign cfg_ext = EW'(queue_limit_r);
  always_comb begin
    if (cfg_ext == '0) begin
      lim = EW'(1);
    end else if (cfg_ext > EW'(MAX_DEPTH)) begin
      lim = EW'(MAX_DEPTH);
    end else begin
      lim = cfg_ext;
    end
  end

  assign cnt_inc   = cnt_r + CW'(1);
  assign serve_now = (EW'(cnt_inc) >= lim);

  always_comb begin
    if (rd_data_r.track > last_track_r) begin
      seek_gap = rd_data_r.track - last_track_r;
    end else begin
      seek_gap = last_track_r - rd_data_r.track;
    end
  end

  // The first entry always seeds the search; strict less-than keeps ties on the older one.
  assign take      = (rd_idx_r == '0) || (served_any_r && (seek_gap < best_r));
  assign rd_last   = rd_vld_r && (rd_idx_r == IW'(cnt_r - CW'(1)));
  assign pick_next = CW'(pick_r) + CW'(1);
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_addr   = iss_r[IW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[IW-1:0];
    wr_data.id    = in_requester_id;
    wr_data.track = in_track;
    case (state_r)
      ST_IDLE: begin
        wr_en = in_acc;
      end
      ST_COMPACT: begin
        wr_en   = rd_vld_r;
        wr_addr = rd_idx_r - IW'(1);
        wr_data = rd_data_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      queue_limit_r <= ssrs_pkg::QUEUE_LIMIT_RESET;
      cnt_r         <= '0;
      iss_r         <= '0;
      rd_vld_r      <= 1'b0;
      rd_idx_r      <= '0;
      last_track_r  <= '0;
      served_any_r  <= 1'b0;
      best_r        <= '0;
      pick_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        queue_limit_r <= cfg_queue_limit;
      end
      // In ST_OUT the valid flag is handled by the state itself.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r    <= cnt_inc;
            iss_r    <= '0;
            rd_vld_r <= 1'b0;
            if (serve_now) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (iss_r < cnt_r) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= iss_r[IW-1:0];
            iss_r    <= iss_r + CW'(1);
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r && take) begin
            best_r     <= seek_gap;
            pick_r     <= rd_idx_r;
            best_ent_r <= rd_data_r;
          end
          if (rd_last) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          rd_vld_r <= 1'b0;
          iss_r    <= pick_next;
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_ent_r    <= best_ent_r;
            last_track_r <= best_ent_r.track;
            served_any_r <= 1'b1;
            if (pick_next == cnt_r) begin
              cnt_r   <= cnt_r - CW'(1);
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_COMPACT;
            end
          end
        end
        ST_COMPACT: begin
          // Entry j is read here and written to j-1 in the next cycle, from the read register.
          if (iss_r < cnt_r) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= iss_r[IW-1:0];
            iss_r    <= iss_r + CW'(1);
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_last) begin
            cnt_r    <= cnt_r - CW'(1);
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/ssrs_chk.sv -----
// Port-level checker for the seek scheduler, bound to the scheduler core.
module ssrs_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ssrs_pkg::ID_W-1:0]  out_served_requester,
  input logic [ssrs_pkg::TRK_W-1:0] out_served_track
);

  // A served result is only produced while the block holds off new requests.
  a_rise_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a preceding busy cycle");

  // Service needs a scan first, so no result can appear right after a transaction.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared one cycle after an input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result was dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_served_requester) && $stable(out_served_track)))
    else $error("stalled result changed");

endmodule

bind shortest_seek_request_scheduler_core ssrs_chk u_ssrs_chk (.*);
